// File: rtl/rtccu_pkg.sv
// rtccu_pkg: shared types, constants and calendar tables for the rtc calendar counter
// no dependencies
`timescale 1ns / 1ps

package rtccu_pkg;

  localparam logic [31:0] EPOCH_2000 = 32'd946684800;
  localparam logic [16:0] SECS_DAY   = 17'd86400;
  localparam logic [11:0] SECS_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_MIN   = 6'd60;
  localparam logic [8:0]  DAYS_YEAR  = 9'd365;

  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [3:0] MONTH_LAST = 4'd12;
  localparam logic [6:0] YEAR_LAST  = 7'd99;

  localparam logic [6:0] MIN_YEAR_RST = 7'd14;
  localparam logic [6:0] MAX_YEAR_RST = 7'd29;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 2'd1;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  // month length, months outside 1..12 count as 31 days
  function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                               input logic [6:0] year);
    logic [4:0] len;
    case (month)
      4'd2:                      len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/rtccu_advance.sv
// rtccu_advance: next calendar state for a tick or a load word
// depends on rtccu_pkg
`timescale 1ns / 1ps

module rtccu_advance
  import rtccu_pkg::*;
(
  input  cal_t    cur,
  input  action_t action,
  input  cal_t    load,
  output cal_t    nxt
);

  cal_t tick;
  logic sec_wrap;
  logic min_wrap;
  logic hour_wrap;
  logic day_wrap;
  logic month_wrap;

  always_comb begin
    sec_wrap   = (cur.second >= SEC_LAST);
    min_wrap   = sec_wrap && (cur.minute >= MIN_LAST);
    hour_wrap  = min_wrap && (cur.hour >= HOUR_LAST);
    day_wrap   = hour_wrap && (cur.day >= days_in_month(cur.month, cur.year));
    month_wrap = day_wrap && (cur.month >= MONTH_LAST);

    tick = cur;
    tick.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
    if (sec_wrap) begin
      tick.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
    end
    if (min_wrap) begin
      tick.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
    end
    if (hour_wrap) begin
      tick.day = day_wrap ? 5'd1 : cur.day + 5'd1;
    end
    if (day_wrap) begin
      tick.month = month_wrap ? 4'd1 : cur.month + 4'd1;
    end
    if (month_wrap) begin
      tick.year = (cur.year >= YEAR_LAST) ? 7'd0 : cur.year + 7'd1;
    end

    nxt = (action == ACT_LOAD) ? load : tick;
  end

endmodule

// File: rtl/rtccu_conv.sv
// rtccu_conv: two-stage conversion of a calendar word to unix seconds and valid flag
// depends on rtccu_pkg
`timescale 1ns / 1ps

module rtccu_conv
  import rtccu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        a_valid,
  input  cal_t        a_cal,
  output logic        a_ready,
  input  logic [6:0]  min_year,
  input  logic [6:0]  max_year,
  output logic        out_valid,
  input  logic        out_ready,
  output cal_t        out_cal,
  output logic [31:0] out_unix,
  output logic        out_time_valid
);

  logic               b_v_r;
  cal_t               b_cal_r;
  logic signed [17:0] b_days_r;
  logic [16:0]        b_sod_r;
  logic               b_tv_r;

  logic               c_v_r;
  cal_t               c_cal_r;
  logic [31:0]        c_unix_r;
  logic               c_tv_r;

  logic               b_ready;
  logic               c_ready;

  logic [15:0]        yr_days;
  logic [5:0]         leap_days;
  logic               leap_adj;
  logic [16:0]        days_pos;
  logic signed [17:0] days_nxt;
  logic [16:0]        sod_nxt;
  logic               tv_nxt;
  logic signed [35:0] day_secs;
  logic [31:0]        unix_nxt;

  assign c_ready = !c_v_r || out_ready;
  assign b_ready = !b_v_r || c_ready;
  assign a_ready = b_ready;

  // stage b: day number since 2000 and seconds of day
  always_comb begin
    yr_days   = 16'(a_cal.year) * 16'(DAYS_YEAR);
    leap_days = 6'((8'(a_cal.year) + 8'd3) >> 2);
    leap_adj  = (a_cal.month > 4'd2) && (a_cal.year[1:0] == 2'd0);
    days_pos  = 17'(yr_days) + 17'(leap_days) + 17'(days_before(a_cal.month))
              + 17'(leap_adj) + 17'(a_cal.day);
    days_nxt  = $signed({1'b0, days_pos}) - 18'sd1;
    sod_nxt   = 17'(a_cal.hour) * 17'(SECS_HOUR) + 17'(a_cal.minute) * 17'(SECS_MIN)
              + 17'(a_cal.second);
    tv_nxt    = (a_cal.year >= min_year) && (a_cal.year <= max_year)
              && (a_cal.month >= 4'd1) && (a_cal.month <= MONTH_LAST)
              && (a_cal.day >= 5'd1) && (a_cal.hour <= HOUR_LAST)
              && (a_cal.minute <= MIN_LAST) && (a_cal.second <= SEC_LAST);
  end

  // stage c: scale days and add epoch
  always_comb begin
    day_secs = b_days_r * $signed({1'b0, SECS_DAY});
    unix_nxt = EPOCH_2000 + day_secs[31:0] + 32'(b_sod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_v_r <= a_valid;
      end
      if (c_ready) begin
        c_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_cal_r  <= a_cal;
      b_days_r <= days_nxt;
      b_sod_r  <= sod_nxt;
      b_tv_r   <= tv_nxt;
    end
    if (c_ready && b_v_r) begin
      c_cal_r  <= b_cal_r;
      c_unix_r <= unix_nxt;
      c_tv_r   <= b_tv_r;
    end
  end

  assign out_valid      = c_v_r;
  assign out_cal        = c_cal_r;
  assign out_unix       = c_unix_r;
  assign out_time_valid = c_tv_r;

endmodule

// File: rtl/rtc_calendar_counter_unix_time.sv
// rtc_calendar_counter_unix_time: real-time calendar counter with unix seconds output
// depends on rtccu_pkg, rtccu_advance, rtccu_conv
//
// usage:
//   input stream in_*: in_tuser is the action (0 tick one second, 1 load);
//   in_tdata carries the load fields, ignored on a tick.
//   result stream out_*: one word per input word with the calendar after the
//   word, unix seconds (2000-01-01 is 946684800, modulo 2^32) and, in
//   out_tuser, the valid flag (year in window, other fields in range).
//   config port cfg_*: index 0 min valid year, index 1 max valid year,
//   other indexes ignored; always ready, write only while idle.
// timing:
//   the calendar update is combinational; the result reaches out_* through the
//   calendar register, the day-number stage and the multiply stage. one word
//   per cycle sustained while out_tready stays high, the carry chain being combinational.
// reset: calendar goes to 2000-01-01 00:00:00, window to years 14..29,
//   pipeline emptied.
// stall: when out_tready is low the stages fill and in_tready drops once
//   all three hold a word; nothing is dropped.
`timescale 1ns / 1ps

module rtc_calendar_counter_unix_time
  import rtccu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // load_year[6:0] load_month[10:7] load_day[15:11] load_hour[20:16]
  // load_minute[26:21] load_second[32:27], zero pad to 40
  input  logic [39:0]          in_tdata,
  // action[0]
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // year[6:0] month[10:7] day[15:11] hour[20:16] minute[26:21]
  // second[32:27] unix_seconds[64:33], zero pad to 72
  output logic [71:0]          out_tdata,
  // time_valid[0]
  output logic                 out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_data
);

  logic [6:0]  min_year_r;
  logic [6:0]  max_year_r;
  cal_t        cal_r;
  cal_t        cal_nxt;
  cal_t        load_cal;
  logic        a_v_r;
  cal_t        a_cal_r;
  logic        a_ready;
  logic        in_acc;
  cal_t        res_cal;
  logic [31:0] res_unix;
  logic        res_tv;

  assign cfg_ready = 1'b1;
  assign in_tready = !a_v_r || a_ready;
  assign in_acc    = in_tvalid && in_tready;

  assign load_cal.year   = in_tdata[6:0];
  assign load_cal.month  = in_tdata[10:7];
  assign load_cal.day    = in_tdata[15:11];
  assign load_cal.hour   = in_tdata[20:16];
  assign load_cal.minute = in_tdata[26:21];
  assign load_cal.second = in_tdata[32:27];

  rtccu_advance u_advance (
    .cur    (cal_r),
    .action (action_t'(in_tuser)),
    .load   (load_cal),
    .nxt    (cal_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
      cal_r      <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                      minute: 6'd0, second: 6'd0};
      a_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_YEAR: min_year_r <= cfg_data;
          REG_MAX_YEAR: max_year_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        cal_r <= cal_nxt;
        a_v_r <= 1'b1;
      end else if (a_ready) begin
        a_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cal_r <= cal_nxt;
    end
  end

  rtccu_conv u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .a_valid        (a_v_r),
    .a_cal          (a_cal_r),
    .a_ready        (a_ready),
    .min_year       (min_year_r),
    .max_year       (max_year_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_cal        (res_cal),
    .out_unix       (res_unix),
    .out_time_valid (res_tv)
  );

  assign out_tdata = {7'd0, res_unix, res_cal.second, res_cal.minute, res_cal.hour,
                      res_cal.day, res_cal.month, res_cal.year};
  assign out_tuser = res_tv;

endmodule

// File: test/tb_rtc_calendar_counter_unix_time.sv
// testbench for rtc_calendar_counter_unix_time: directed loads around rollovers, then
// random time sequences under several window settings and handshake stall patterns
// depends on rtccu_pkg and rtc_calendar_counter_unix_time
`timescale 1ns / 1ps

module tb_rtc_calendar_counter_unix_time;
  import rtccu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [31:0] UNIX_AT_2000 = 32'd946684800;
  localparam logic [31:0] YEAR_SECS    = 32'd31536000;
  localparam logic [31:0] DAY_SECS     = 32'd86400;
  localparam logic [31:0] HOUR_SECS    = 32'd3600;
  localparam logic [31:0] MIN_SECS     = 32'd60;

  typedef struct {
    cal_t        cal;
    logic [31:0] unix;
    logic        ok;
  } calendar_reading_t;

  class calendar_tracker;
    cal_t              now;
    logic [6:0]        lo_year;
    logic [6:0]        hi_year;
    calendar_reading_t awaited_readings[$];
    int                errors;

    function new();
      now = '0;
      now.day = 5'd1;
      now.month = 4'd1;
      lo_year = 7'd14;
      hi_year = 7'd29;
      errors = 0;
    endfunction

    function int month_length(logic [3:0] mo, logic [6:0] yr);
      case (mo)
        4'd2:                    return (yr % 4 == 0) ? 29 : 28;
        4'd4, 4'd6, 4'd9, 4'd11: return 30;
        default:                 return 31;
      endcase
    endfunction

    // days elapsed before the first of a month, common year
    function logic [31:0] days_ahead(logic [3:0] mo);
      case (mo)
        4'd2:    return 32'd31;
        4'd3:    return 32'd59;
        4'd4:    return 32'd90;
        4'd5:    return 32'd120;
        4'd6:    return 32'd151;
        4'd7:    return 32'd181;
        4'd8:    return 32'd212;
        4'd9:    return 32'd243;
        4'd10:   return 32'd273;
        4'd11:   return 32'd304;
        4'd12:   return 32'd334;
        default: return 32'd0;
      endcase
    endfunction

    function void step_calendar();
      int nxt;
      nxt = now.second + 1;
      if (nxt <= 59) begin
        now.second = 6'(nxt);
        return;
      end
      now.second = '0;
      nxt = now.minute + 1;
      if (nxt <= 59) begin
        now.minute = 6'(nxt);
        return;
      end
      now.minute = '0;
      nxt = now.hour + 1;
      if (nxt <= 23) begin
        now.hour = 5'(nxt);
        return;
      end
      now.hour = '0;
      nxt = now.day + 1;
      if (nxt <= month_length(now.month, now.year)) begin
        now.day = 5'(nxt);
        return;
      end
      now.day = 5'd1;
      nxt = now.month + 1;
      if (nxt <= 12) begin
        now.month = 4'(nxt);
        return;
      end
      now.month = 4'd1;
      now.year = (now.year >= 7'd99) ? 7'd0 : now.year + 7'd1;
    endfunction

    function logic [31:0] unix_time_of(cal_t c);
      logic [31:0] r, yr, mo, dy, hr, mi, sc;
      yr = c.year;
      mo = c.month;
      dy = c.day;
      hr = c.hour;
      mi = c.minute;
      sc = c.second;
      r = UNIX_AT_2000 + yr * YEAR_SECS;
      if (yr != 0) r = r + DAY_SECS + ((yr - 32'd1) / 32'd4) * DAY_SECS;
      if (mo >= 1 && mo <= 12) r = r + days_ahead(c.month) * DAY_SECS;
      if (mo > 2 && yr % 4 == 0) r = r + DAY_SECS;
      r = r + (dy - 32'd1) * DAY_SECS + hr * HOUR_SECS + mi * MIN_SECS + sc;
      return r;
    endfunction

    function logic in_window();
      return now.year >= lo_year && now.year <= hi_year &&
             now.month >= 1 && now.month <= 12 && now.day >= 1 && now.day <= 31 &&
             now.hour <= 23 && now.minute <= 59 && now.second <= 59;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
      if (idx == REG_MIN_YEAR) lo_year = val;
      else if (idx == REG_MAX_YEAR) hi_year = val;
    endfunction

    function void take_word(logic act, logic [39:0] word);
      calendar_reading_t r;
      if (act == ACT_LOAD) begin
        now.year = word[6:0];
        now.month = word[10:7];
        now.day = word[15:11];
        now.hour = word[20:16];
        now.minute = word[26:21];
        now.second = word[32:27];
      end else begin
        step_calendar();
      end
      r.cal = now;
      r.unix = unix_time_of(now);
      r.ok = in_window();
      awaited_readings.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reading(logic [71:0] word, logic flag);
      calendar_reading_t want;
      if (awaited_readings.size() == 0) begin
        $display("%0t unexpected word: expected none, got %h", $time, word);
        errors++;
        return;
      end
      want = awaited_readings.pop_front();
      compare("year", want.cal.year, word[6:0]);
      compare("month", want.cal.month, word[10:7]);
      compare("day", want.cal.day, word[15:11]);
      compare("hour", want.cal.hour, word[20:16]);
      compare("minute", want.cal.minute, word[26:21]);
      compare("second", want.cal.second, word[32:27]);
      compare("unix_seconds", want.unix, word[64:33]);
      compare("time_valid", want.ok, flag);
    endfunction

    function int pending();
      return awaited_readings.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // load_year load_month load_day load_hour load_minute load_second, zero pad
  logic [39:0]          in_tdata = '0;
  // action
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // year month day hour minute second unix_seconds, zero pad
  logic [71:0]          out_tdata;
  // time_valid
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0]           cfg_data = '0;

  calendar_tracker sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  rtc_calendar_counter_unix_time dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.take_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_reading(out_tdata, out_tuser);
    end
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  task automatic send_word(input logic act, input cal_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {7'd0, c.second, c.minute, c.hour, c.day, c.month, c.year};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick_n(input int n);
    cal_t junk;
    repeat (n) begin
      junk = cal_t'(33'({$urandom, $urandom}));
      send_word(ACT_TICK, junk);
    end
  endtask

  task automatic load_time(input logic [6:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                           input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] sc);
    cal_t c;
    c.year = yr;
    c.month = mo;
    c.day = dy;
    c.hour = hr;
    c.minute = mi;
    c.second = sc;
    send_word(ACT_LOAD, c);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 77; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 77; end
      default: begin idle_pct = 8; stall_pct = 8; end
    endcase
  endtask

  // mostly loads just short of a rollover followed by ticks, some bare ticks, some noise
  task automatic random_run(input int n);
    int   start;
    int   pick;
    int   len;
    cal_t c;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        c.year = ($urandom_range(3) == 0) ? 7'd99 : 7'($urandom_range(99));
        c.month = ($urandom_range(3) == 0) ? 4'd12 : 4'($urandom_range(12, 1));
        len = sb.month_length(c.month, c.year);
        c.day = $urandom_range(1) ? 5'(len) : 5'($urandom_range(len, 1));
        c.hour = $urandom_range(1) ? 5'd23 : 5'($urandom_range(23));
        c.minute = $urandom_range(1) ? 6'd59 : 6'($urandom_range(59));
        c.second = 6'($urandom_range(59, 55));
        send_word(ACT_LOAD, c);
        tick_n($urandom_range(8, 1));
      end else if (pick < 85) begin
        tick_n($urandom_range(5, 1));
      end else begin
        c = cal_t'(33'({$urandom, $urandom}));
        send_word(ACT_LOAD, c);
        tick_n($urandom_range(3));
      end
    end
  endtask

  initial begin
    int         p;
    logic [6:0] lo_y;
    logic [6:0] hi_y;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_pacing(0);
    tick_n(1);
    load_time(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    tick_n(1);
    load_time(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    tick_n(1);
    load_time(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    tick_n(1);
    load_time(7'd4, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
    tick_n(1);
    load_time(7'd4, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59);
    tick_n(1);
    load_time(7'd5, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
    tick_n(1);
    load_time(7'd14, 4'd4, 5'd31, 5'd23, 6'd59, 6'd59);
    tick_n(1);
    load_time(7'd29, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59);
    tick_n(1);
    load_time(7'd30, 4'd6, 5'd15, 5'd24, 6'd60, 6'd58);
    tick_n(2);
    load_time(7'd13, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    load_time(7'd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    tick_n(1);

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin lo_y = 7'd0;   hi_y = 7'd99;  end
        1: begin lo_y = 7'd99;  hi_y = 7'd0;   end
        2: begin lo_y = 7'd0;   hi_y = 7'd127; end
        3: begin lo_y = 7'd127; hi_y = 7'd127; end
        4: begin lo_y = 7'd50;  hi_y = 7'd50;  end
        default: begin lo_y = 7'd14; hi_y = 7'd29; end
      endcase
      write_reg(REG_MIN_YEAR, lo_y);
      write_reg(REG_MAX_YEAR, hi_y);
      if (p == 2) write_reg(REG_SPARE, 7'd127);
      set_pacing(p % 4);
      random_run(120);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
